@@ src/websocket_frame_deframer_assert.svh @@
// ============================================================================
// WebSocket frame deframer: assertion macros
// Concurrent assertion helpers, clocked on aclk; they compile to nothing when
// NO_ASSERTIONS is defined.
// ============================================================================
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only while the block is out of reset.
`define WSFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define WSFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define WSFD_ASSERT(lbl, prop, msg)
`define WSFD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ src/wsfd_pkg.sv @@
// ============================================================================
// WebSocket frame deframer: shared package
// Phase encoding, header constants and the structs passed between modules.
// ============================================================================
package wsfd_pkg;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_PAYLOAD
    } phase_t;

    localparam logic [3:0] OPCODE_MASK = 4'hF;
    localparam logic [6:0] LEN7_MASK   = 7'h7F;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [6:0] LEN_EMPTY   = 7'd0;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    // One payload beat on its way to the output register.
    typedef struct packed {
        logic [7:0] payload;
        logic [3:0] opcode;
        logic       last;
    } result_t;

    // Parser status seen by the top level.
    typedef struct packed {
        logic in_hdr0;
        logic result_valid;
        logic count_zero;
    } parser_stat_t;

endpackage

@@ src/wsfd_parser.sv @@
// ============================================================================
// WebSocket frame deframer: header parser
// Holds the frame phase, opcode and payload count, and works out the result
// for the byte in the input register in a single pass.
// ============================================================================
module wsfd_parser import wsfd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   byte_in,
    output result_t      result,
    output parser_stat_t stat
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [63:0] count_reg, count_next;

    logic [6:0]  len7;
    logic [63:0] ext_count;
    logic [63:0] count_after;
    logic        count_zero;

    assign len7        = byte_in[6:0] & LEN7_MASK;
    assign ext_count   = {count_reg[55:0], byte_in};
    assign count_zero  = (count_reg == 64'd0);
    assign count_after = count_zero ? 64'd0 : count_reg - 64'd1;

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            unique case (phase_reg)
                PH_HDR0: begin
                    phase_next = PH_HDR1;
                end
                PH_HDR1: begin
                    if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                        phase_next = PH_EXT;
                    end else if (len7 == LEN_EMPTY) begin
                        phase_next = PH_HDR0;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_EXT: begin
                    if (ext_left_reg == 4'd1) begin
                        phase_next = (ext_count == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (count_after == 64'd0) begin
                        phase_next = PH_HDR0;
                    end
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

    // Counters, opcode and result.
    always_comb begin
        opcode_next   = opcode_reg;
        ext_left_next = ext_left_reg;
        count_next    = count_reg;
        if (step) begin
            unique case (phase_reg)
                PH_HDR0: begin
                    opcode_next = byte_in[3:0] & OPCODE_MASK;
                end
                PH_HDR1: begin
                    if (len7 == LEN_EXT16) begin
                        ext_left_next = EXT16_BYTES;
                        count_next    = 64'd0;
                    end else if (len7 == LEN_EXT64) begin
                        ext_left_next = EXT64_BYTES;
                        count_next    = 64'd0;
                    end else begin
                        count_next    = {57'd0, len7};
                    end
                end
                PH_EXT: begin
                    count_next    = ext_count;
                    ext_left_next = ext_left_reg - 4'd1;
                end
                PH_PAYLOAD: begin
                    count_next = count_after;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign result.payload = byte_in;
    assign result.opcode  = opcode_reg;
    assign result.last    = (count_reg[63:1] == 63'd0);

    assign stat.in_hdr0      = (phase_reg == PH_HDR0);
    assign stat.result_valid = (phase_reg == PH_PAYLOAD);
    assign stat.count_zero   = count_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR0;
            opcode_reg   <= 4'd0;
            ext_left_reg <= 4'd0;
            count_reg    <= 64'd0;
        end else begin
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            ext_left_reg <= ext_left_next;
            count_reg    <= count_next;
        end
    end

endmodule

@@ src/wsfd_out_reg.sv @@
// ============================================================================
// WebSocket frame deframer: output register
// Holds one result beat for the master side until it is taken.
// ============================================================================
module wsfd_out_reg import wsfd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  result_t    result,
    output logic       out_free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [3:0] m_tuser,
    output logic       m_tlast
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign out_free   = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.payload;
    assign m_tuser  = data_reg.opcode;
    assign m_tlast  = data_reg.last;

endmodule

@@ src/websocket_frame_deframer.sv @@
// ============================================================================
// WebSocket frame deframer
// Splits a server-to-client WebSocket byte stream into frame payload beats.
// ============================================================================
// The slave side takes the link stream one byte per beat on s_tdata. Header
// byte 0 supplies the opcode (its low nibble), header byte 1 a seven-bit
// length, followed by two or eight big-endian extended length bytes where the
// length code asks for them. Header bytes produce nothing on the master side.
// Every payload byte leaves as one master beat: the byte on m_tdata, the
// frame's opcode on m_tuser, and m_tlast high on the frame's final byte.
// Frames of zero length produce no beats at all. FIN, RSV and mask bits are
// ignored and the payload is passed on unmasked.
// Each accepted byte sits in an input register while the parser works on it,
// and a resulting beat is loaded into the output register at the end of the
// cycle in which the byte is consumed; m_tvalid rises once it is registered.
// One byte is taken per cycle while s_tready is high; the rate is set by the
// single parser pass between the input and output registers. While the
// master side stalls, header bytes keep flowing, and a payload byte waits in
// the input register, so s_tready drops only when both registers hold a beat.
// A synchronous reset (aresetn low) returns the parser to waiting for header
// byte 0 and empties both registers.
// ============================================================================
module websocket_frame_deframer import wsfd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] stream_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic [3:0] m_tuser,   // [3:0] frame_opcode
    output logic       m_tlast    // last_of_frame
);

`include "websocket_frame_deframer_assert.svh"

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_take;
    logic         consume;
    logic         out_free;
    logic         out_load;
    result_t      result;
    parser_stat_t stat;

    // A held byte moves on once its result, if any, has room downstream.
    assign consume  = in_valid_reg && (!stat.result_valid || out_free);
    assign out_load = consume && stat.result_valid;

    assign s_tready      = !in_valid_reg || consume;
    assign in_take       = s_tvalid && s_tready;
    assign in_valid_next = in_take || (in_valid_reg && !consume);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg <= s_tdata;
        end
    end

    wsfd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (consume),
        .byte_in (in_byte_reg),
        .result  (result),
        .stat    (stat)
    );

    wsfd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The payload phase is only entered with bytes still owed.
    `WSFD_ASSERT(a_payload_count_live, stat.result_valid |-> !stat.count_zero, "payload phase with zero count")

    // The final byte of a frame sends the parser back to header byte 0.
    `WSFD_ASSERT(a_last_ends_frame, (out_load && result.last) |=> stat.in_hdr0, "frame did not end after last byte")

    // A held byte that is not consumed is never dropped.
    `WSFD_ASSERT(a_in_hold, (in_valid_reg && !consume) |=> (in_valid_reg && $stable(in_byte_reg)), "input byte lost while stalled")

    // Nothing is loaded into the output register while it holds a beat that is not being taken.
    `WSFD_ASSERT_ALWAYS(a_no_overwrite, (m_tvalid && !m_tready) |-> !out_load, "output beat overwritten")

endmodule
